[sv/ssim_pkg.sv]
// Shared types, codes and default sizes of the sparse set index map.
package ssim_pkg;

  // Fixed field widths of the item and result beats.
  localparam int ID_BITS     = 10;
  localparam int STATUS_BITS = 3;
  localparam int COUNT_BITS  = 11;

  // Default sizes handed to the top level parameters.
  localparam int MAX_IDS_DEF  = 1024;
  localparam int CAPACITY_DEF = 1024;
  localparam int POS_BITS_DEF = 40;

  // Operation codes carried in the opcode field.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_ERASE  = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_BITS-1:0] {
    STAT_INSERTED = 3'd0,
    STAT_UPDATED  = 3'd1,
    STAT_ERASED   = 3'd2,
    STAT_ABSENT   = 3'd3,
    STAT_FULL     = 3'd4
  } ssim_status_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } ssim_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // take the input beat and launch the table reads
    logic commit;    // apply the table writes and load the result register
    logic clear_wr;  // clear one presence entry of the reset sweep
  } ssim_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;  // the sweep is at its final presence entry
  } ssim_sts_t;

endpackage

[sv/ssim_ctrl.sv]
// Controller state machine: reset sweep, beat handshakes and step sequencing.
module ssim_ctrl
  import ssim_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  ssim_sts_t sts,
  output ssim_cmd_t cmd
);

  ssim_state_t state_r;
  ssim_state_t state_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        out_free;

  // The result register can take a new result when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
      end
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_EXEC: begin
        cmd.commit = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // Result beat valid: set on commit, held while the sink stalls.
  assign out_valid_nxt = cmd.commit || (out_valid_r && out_stall);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[sv/ssim_datapath.sv]
// Datapath: presence, sparse and dense tables, entry count and result register.
module ssim_datapath
  import ssim_pkg::*;
#(
  parameter int MAX_IDS  = MAX_IDS_DEF,
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ssim_cmd_t              cmd,
  output ssim_sts_t              sts,
  input  logic                   in_opcode,
  input  logic [ID_BITS-1:0]     in_entity_id,
  input  logic [POS_BITS-1:0]    in_position_word,
  output logic [STATUS_BITS-1:0] out_status,
  output logic [COUNT_BITS-1:0]  out_live_count
);

  localparam int ID_W   = $clog2(MAX_IDS);
  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  // Tables.
  logic               pres_mem   [MAX_IDS];
  logic [SLOT_W-1:0]  sparse_mem [MAX_IDS];
  logic [POS_BITS-1:0] pos_mem   [CAPACITY];
  logic [ID_BITS-1:0] owner_mem  [CAPACITY];

  // Captured beat and registered table reads.
  logic                op_r;
  logic [ID_BITS-1:0]  id_r;
  logic [POS_BITS-1:0] pos_r;
  logic                pres_rd_r;
  logic [SLOT_W-1:0]   slot_rd_r;
  logic [POS_BITS-1:0] pos_last_rd_r;
  logic [ID_BITS-1:0]  owner_last_rd_r;

  // Control state and result register.
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [ID_W-1:0]  clr_idx_r;
  ssim_status_t     out_status_r;
  logic [CNT_W-1:0] out_count_r;

  // Step decision.
  ssim_status_t        status_nxt;
  logic [SLOT_W-1:0]   last_slot;
  logic [SLOT_W-1:0]   rd_last_slot;
  logic                in_range;
  logic                hit;
  logic                pres_we;
  logic [ID_W-1:0]     pres_waddr;
  logic                pres_wdata;
  logic                sparse_we;
  logic [ID_W-1:0]     sparse_waddr;
  logic [SLOT_W-1:0]   sparse_wdata;
  logic                pos_we;
  logic [SLOT_W-1:0]   pos_waddr;
  logic [POS_BITS-1:0] pos_wdata;
  logic                own_we;
  logic [SLOT_W-1:0]   own_waddr;
  logic [ID_BITS-1:0]  own_wdata;
  logic                step_pres_we;
  logic                step_pres_data;

  // Reset sweep over the presence table.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd.clear_wr) begin
      clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  assign sts.clear_last = (clr_idx_r == ID_W'(MAX_IDS - 1));

  // Capture the beat; the dense reads target the current last entry.
  assign rd_last_slot = SLOT_W'(count_r - 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_opcode;
      id_r  <= in_entity_id;
      pos_r <= in_position_word;
    end
  end

  // The id test and the dense slot decision for the captured beat.
  assign in_range  = (32'(id_r) < MAX_IDS);
  assign last_slot = SLOT_W'(count_r - 1'b1);
  assign hit       = in_range && pres_rd_r && (CNT_W'(slot_rd_r) < count_r);

  always_comb begin
    status_nxt     = STAT_FULL;
    count_nxt      = count_r;
    step_pres_we   = 1'b0;
    step_pres_data = 1'b0;
    sparse_we      = 1'b0;
    sparse_waddr   = ID_W'(id_r);
    sparse_wdata   = SLOT_W'(count_r);
    pos_we         = 1'b0;
    pos_waddr      = slot_rd_r;
    pos_wdata      = pos_r;
    own_we         = 1'b0;
    own_waddr      = SLOT_W'(count_r);
    own_wdata      = id_r;
    if (op_r == OP_ERASE) begin
      if (hit) begin
        status_nxt   = STAT_ERASED;
        count_nxt    = count_r - 1'b1;
        step_pres_we = 1'b1;
        // Move the last entry into the freed slot unless it is that slot.
        if (slot_rd_r != last_slot) begin
          pos_we       = 1'b1;
          pos_waddr    = slot_rd_r;
          pos_wdata    = pos_last_rd_r;
          own_we       = 1'b1;
          own_waddr    = slot_rd_r;
          own_wdata    = owner_last_rd_r;
          sparse_we    = 1'b1;
          sparse_waddr = ID_W'(owner_last_rd_r);
          sparse_wdata = slot_rd_r;
        end
      end else begin
        status_nxt = STAT_ABSENT;
      end
    end else begin
      if (!in_range) begin
        status_nxt = STAT_FULL;
      end else if (hit) begin
        status_nxt = STAT_UPDATED;
        pos_we     = 1'b1;
      end else if (count_r >= CNT_W'(CAPACITY)) begin
        status_nxt = STAT_FULL;
      end else begin
        // Append at the dense end.
        status_nxt     = STAT_INSERTED;
        count_nxt      = count_r + 1'b1;
        step_pres_we   = 1'b1;
        step_pres_data = 1'b1;
        sparse_we      = 1'b1;
        pos_we         = 1'b1;
        pos_waddr      = SLOT_W'(count_r);
        own_we         = 1'b1;
      end
    end
  end

  // Presence writes come from the sweep or from a committed step.
  always_comb begin
    if (cmd.clear_wr) begin
      pres_we    = 1'b1;
      pres_waddr = clr_idx_r;
      pres_wdata = 1'b0;
    end else begin
      pres_we    = cmd.commit && step_pres_we;
      pres_waddr = ID_W'(id_r);
      pres_wdata = step_pres_data;
    end
  end

  // Presence table.
  always_ff @(posedge clk) begin
    if (pres_we) begin
      pres_mem[pres_waddr] <= pres_wdata;
    end
    if (cmd.capture) begin
      pres_rd_r <= pres_mem[ID_W'(in_entity_id)];
    end
  end

  // Sparse table.
  always_ff @(posedge clk) begin
    if (cmd.commit && sparse_we) begin
      sparse_mem[sparse_waddr] <= sparse_wdata;
    end
    if (cmd.capture) begin
      slot_rd_r <= sparse_mem[ID_W'(in_entity_id)];
    end
  end

  // Dense position table.
  always_ff @(posedge clk) begin
    if (cmd.commit && pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    if (cmd.capture) begin
      pos_last_rd_r <= pos_mem[rd_last_slot];
    end
  end

  // Dense owner table.
  always_ff @(posedge clk) begin
    if (cmd.commit && own_we) begin
      owner_mem[own_waddr] <= own_wdata;
    end
    if (cmd.capture) begin
      owner_last_rd_r <= owner_mem[rd_last_slot];
    end
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= status_nxt;
      out_count_r  <= count_nxt;
    end
  end

  assign out_status     = out_status_r;
  assign out_live_count = COUNT_BITS'(out_count_r);

`ifndef ASSERT_OFF
  // The dense table never holds more entries than it has slots.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // An erase shrinks the count by one.
  a_erase_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && status_nxt == STAT_ERASED) |=> (count_r == $past(count_r) - 1'b1))
    else $error("erase did not shrink the count");

  // An insert of a new id grows the count by one.
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && status_nxt == STAT_INSERTED) |=> (count_r == $past(count_r) + 1'b1))
    else $error("insert did not grow the count");

  // Updates, misses and full answers leave the count alone.
  a_count_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && (status_nxt == STAT_UPDATED || status_nxt == STAT_ABSENT ||
                    status_nxt == STAT_FULL)) |=> $stable(count_r))
    else $error("count changed without insert or erase");

  // No step runs while the presence sweep is still going.
  a_sweep_alone: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_wr |-> (!cmd.commit && !cmd.capture))
    else $error("step overlapped the reset sweep");
`endif

endmodule

[sv/sparse_set_index_map.sv]
// Top level of the sparse set index map: controller and datapath.
//
//   Channel  Ports                                         Direction
//   in       in_valid in_stall in_opcode in_entity_id      sink
//            in_position_word
//   out      out_valid out_stall out_status out_live_count source
//
// Each operation first does the registered reads of the presence and sparse
// tables and of the last dense entry, then the table writes.
// After reset a sweep clears all MAX_IDS presence entries (1024 by default),
// with in_stall high throughout.
// A new beat is taken while the previous result still waits; a stalled result
// holds the next operation in its write cycle until the result is taken.
module sparse_set_index_map
  import ssim_pkg::*;
#(
  parameter int MAX_IDS  = MAX_IDS_DEF,
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_opcode,
  input  logic [ID_BITS-1:0]     in_entity_id,
  input  logic [POS_BITS-1:0]    in_position_word,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [STATUS_BITS-1:0] out_status,
  output logic [COUNT_BITS-1:0]  out_live_count
);

  ssim_cmd_t cmd;
  ssim_sts_t sts;

  // Sequencing and handshakes.
  ssim_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Tables, count and result payload.
  ssim_datapath #(
    .MAX_IDS  (MAX_IDS),
    .CAPACITY (CAPACITY),
    .POS_BITS (POS_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_opcode        (in_opcode),
    .in_entity_id     (in_entity_id),
    .in_position_word (in_position_word),
    .out_status       (out_status),
    .out_live_count   (out_live_count)
  );

endmodule
